// ===== hw/rtl/bcdt_pkg.sv =====
`timescale 1ns / 1ps

package bcdt_pkg;

  // Digits that the four-nibble BCD words can hold.
  localparam int unsigned MAX_DIGITS = 4;
  localparam int unsigned BCD_W      = 4 * MAX_DIGITS;
  localparam int unsigned SEG_W      = 7 * MAX_DIGITS;
  localparam int unsigned ACC_W      = 13;
  localparam int unsigned TICK_W     = 9;
  localparam int unsigned MPS_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ACC_W-1:0]  ACC_MAX    = 13'd8191;
  localparam logic [BCD_W-1:0]  PRESET_RST = 16'd32;
  localparam logic [TICK_W-1:0] TICK_RST   = 9'd20;
  localparam logic [MPS_W-1:0]  MPS_RST    = 12'd1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_SECOND = 2'd2;

  // Button positions in the debounce vector.
  localparam int unsigned BTN_INC   = 0;
  localparam int unsigned BTN_DEC   = 1;
  localparam int unsigned BTN_START = 2;
  localparam int unsigned BTN_SAVE  = 3;

  // Segments a..g, a in bit 0, 1 means lit. Non-decimal codes stay dark.
  function automatic logic [6:0] seg_of_digit(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== hw/rtl/bcdt_bcd_step.sv =====
`timescale 1ns / 1ps

// Adds or subtracts one on a BCD word, wrapping across the digits in use.
module bcdt_bcd_step #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic [bcdt_pkg::BCD_W-1:0] val_i,
  input  logic                       down_i,
  output logic [bcdt_pkg::BCD_W-1:0] val_o
);
  import bcdt_pkg::*;

  logic       carry;
  logic [3:0] digit;

  always_comb begin
    carry = 1'b1;
    val_o = '0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      digit = val_i[4*k +: 4];
      if (k < NUM_DIGITS) begin
        if (carry) begin
          if (down_i) begin
            if (digit == 4'd0) begin
              val_o[4*k +: 4] = 4'd9;
            end else begin
              val_o[4*k +: 4] = digit - 4'd1;
              carry           = 1'b0;
            end
          end else begin
            if (digit >= 4'd9) begin
              val_o[4*k +: 4] = 4'd0;
            end else begin
              val_o[4*k +: 4] = digit + 4'd1;
              carry           = 1'b0;
            end
          end
        end else begin
          val_o[4*k +: 4] = digit;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/bcdt_seg_enc.sv =====
`timescale 1ns / 1ps

// Seven-segment patterns for every digit in use; unused digits stay dark.
module bcdt_seg_enc #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic [bcdt_pkg::BCD_W-1:0] val_i,
  output logic [bcdt_pkg::SEG_W-1:0] seg_o
);
  import bcdt_pkg::*;

  always_comb begin
    seg_o = '0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (k < NUM_DIGITS) begin
        seg_o[7*k +: 7] = seg_of_digit(val_i[4*k +: 4]);
      end
    end
  end

endmodule

// ===== hw/rtl/bcd_countdown_timer_controller.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Width  Contents
// s_axis     in   8      one tick: button levels inc, dec, start, save
// m_axis     out  64     one result per tick: relay, display, segments, save
// cfg        in   2+16   register writes: preset_time, tick_ms, ms_per_second
//
// The timer state is updated at the edge that accepts the beat, and the result
// lands in the output register at that edge.
// A new tick is accepted every cycle while the output register is empty or
// being drained, so a stalled consumer holds back the input side once one result waits.
// Reset loads the setting with the preset, clears the countdown, accumulator
// and running flag, and marks all buttons as released.
module bcd_countdown_timer_controller #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [0] inc_button, [1] dec_button, [2] start_button, [3] save_button,
  // [7:4] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // tdata: [0] relay_on, [16:1] display_value, [44:17] segment_pattern,
  // [45] save_strobe, [61:46] saved_value, [63:62] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [bcdt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bcdt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bcdt_pkg::*;

  // Only up to four digits fit in the 16-bit words.
  localparam int unsigned NDIG = (DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT;
  localparam logic [BCD_W-1:0] DIGIT_MASK = BCD_W'((33'd1 << (4 * NDIG)) - 33'd1);

  // Timer state.
  logic [BCD_W-1:0]  setting_q, setting_d;
  logic [BCD_W-1:0]  count_q, count_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              running_q, running_d;
  logic [3:0]        released_q, released_d;
  // Configuration.
  logic [TICK_W-1:0] tick_q;
  logic [MPS_W-1:0]  mps_q;
  // Output register.
  logic              out_valid_q;
  logic [63:0]       out_data_q, out_data_d;

  logic accept;
  logic btn_inc, btn_dec, btn_start, btn_save;
  logic inc_act, dec_act, save_act, start_act;

  logic [BCD_W-1:0] set_inc, set_after_inc, set_dec, set_after_dec;
  logic [BCD_W-1:0] count_mid, count_dec, shown;
  logic [SEG_W-1:0] shown_seg;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_run, acc_mid;
  logic             run_mid;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign btn_inc   = s_axis_tdata[BTN_INC];
  assign btn_dec   = s_axis_tdata[BTN_DEC];
  assign btn_start = s_axis_tdata[BTN_START];
  assign btn_save  = s_axis_tdata[BTN_SAVE];

  // Buttons act on a fresh press only; inc, dec and save also need the
  // timer to be idle at the start of the tick.
  assign inc_act   = ~running_q & btn_inc & released_q[BTN_INC];
  assign dec_act   = ~running_q & btn_dec & released_q[BTN_DEC];
  assign save_act  = ~running_q & btn_save & released_q[BTN_SAVE];
  assign start_act = btn_start & released_q[BTN_START];

  always_comb begin
    released_d            = released_q;
    released_d[BTN_INC]   = ~(~running_q & btn_inc);
    released_d[BTN_DEC]   = ~(~running_q & btn_dec);
    released_d[BTN_SAVE]  = ~(~running_q & btn_save);
    released_d[BTN_START] = ~btn_start;
  end

  // Setting: increment first, then decrement, both possible in one tick.
  bcdt_bcd_step #(.NUM_DIGITS(NDIG)) u_set_inc (
    .val_i (setting_q),
    .down_i(1'b0),
    .val_o (set_inc)
  );
  assign set_after_inc = inc_act ? set_inc : setting_q;

  bcdt_bcd_step #(.NUM_DIGITS(NDIG)) u_set_dec (
    .val_i (set_after_inc),
    .down_i(1'b1),
    .val_o (set_dec)
  );
  assign set_after_dec = dec_act ? set_dec : set_after_inc;

  // Accumulator gains tick_ms per running tick and saturates.
  assign acc_sum = {1'b0, acc_q} + {{(ACC_W + 1 - TICK_W){1'b0}}, tick_q};
  assign acc_run = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

  // Start toggles: it stops a running count or launches a nonzero setting.
  always_comb begin
    count_mid = count_q;
    acc_mid   = running_q ? acc_run : acc_q;
    run_mid   = running_q;
    if (start_act) begin
      if (running_q) begin
        run_mid = 1'b0;
      end else if (set_after_dec != '0) begin
        count_mid = set_after_dec;
        acc_mid   = '0;
        run_mid   = 1'b1;
      end
    end
  end

  bcdt_bcd_step #(.NUM_DIGITS(NDIG)) u_count_dec (
    .val_i (count_mid),
    .down_i(1'b1),
    .val_o (count_dec)
  );

  // One second elapsed: step the countdown and stop when it reaches zero.
  always_comb begin
    count_d   = count_mid;
    acc_d     = acc_mid;
    running_d = run_mid;
    if (run_mid && (acc_mid >= {{(ACC_W - MPS_W){1'b0}}, mps_q})) begin
      count_d   = count_dec;
      acc_d     = acc_mid - {{(ACC_W - MPS_W){1'b0}}, mps_q};
      running_d = (count_dec != '0);
    end
  end

  // A preset write reloads the setting; writes must come only while idle (not enforced here).
  always_comb begin
    setting_d = setting_q;
    if (accept) begin
      setting_d = set_after_dec;
    end
    if (cfg_we_i && (cfg_idx_i == CFG_PRESET_TIME)) begin
      setting_d = cfg_data_i[BCD_W-1:0] & DIGIT_MASK;
    end
  end

  // The display shows the state from before this tick's update.
  assign shown = running_q ? count_q : setting_q;

  bcdt_seg_enc #(.NUM_DIGITS(NDIG)) u_seg (
    .val_i(shown),
    .seg_o(shown_seg)
  );

  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = running_d;
    out_data_d[16:1]  = shown;
    out_data_d[44:17] = shown_seg;
    out_data_d[45]    = save_act;
    out_data_d[61:46] = save_act ? set_after_dec : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q   <= PRESET_RST & DIGIT_MASK;
      count_q     <= '0;
      acc_q       <= '0;
      running_q   <= 1'b0;
      released_q  <= '1;
      tick_q      <= TICK_RST;
      mps_q       <= MPS_RST;
      out_valid_q <= 1'b0;
    end else begin
      setting_q <= setting_d;
      if (accept) begin
        count_q    <= count_d;
        acc_q      <= acc_d;
        running_q  <= running_d;
        released_q <= released_d;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_TICK_MS)) begin
        tick_q <= cfg_data_i[TICK_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_MS_PER_SECOND)) begin
        mps_q <= cfg_data_i[MPS_W-1:0];
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  // The relay bit of a result is the running flag that its tick left behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (m_axis_tdata[0] == running_q))
    else $error("relay bit differs from running state");

  // A running count never sits at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (count_q != '0))
    else $error("running with a zero countdown");

  // An empty output register never holds back the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Digits beyond those in use stay zero in the setting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((setting_q & ~DIGIT_MASK) == '0))
    else $error("unused setting digits not zero");

endmodule

// ===== tb/bcd_countdown_timer_controller_test.sv =====
`timescale 1ns / 1ps

module bcd_countdown_timer_controller_test;
  import bcdt_pkg::*;

  localparam int unsigned DIGITS        = 4;
  localparam int unsigned ACTIVE_DIGITS = (DIGITS < 1) ? 1 : ((DIGITS > 4) ? 4 : DIGITS);
  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned IDLE_PCT      = 34;
  localparam int unsigned SAT_LIMIT     = 8191;

  localparam logic [BCD_W-1:0] DIGIT_MASK = BCD_W'((32'd1 << (4 * ACTIVE_DIGITS)) - 1);

  // Segment glyphs for the decimal digits, digit 0 in the lowest seven bits.
  localparam logic [9:0][6:0] GLYPHS = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  // Button codes for one tick, in the bit order of the input beat.
  localparam logic [3:0] PRESS_NONE  = 4'b0000;
  localparam logic [3:0] PRESS_INC   = 4'b0001;
  localparam logic [3:0] PRESS_DEC   = 4'b0010;
  localparam logic [3:0] PRESS_START = 4'b0100;
  localparam logic [3:0] PRESS_SAVE  = 4'b1000;

  // Input beat, lowest bit up: inc_button, dec_button, start_button, save_button, zero pad.
  typedef struct packed {
    logic [3:0] pad;
    logic       save;
    logic       start;
    logic       dec;
    logic       inc;
  } buttons_t;

  // Output beat, lowest bit up: relay_on, display_value, segment_pattern,
  // save_strobe, saved_value, zero pad.
  typedef struct packed {
    logic [1:0]       pad;
    logic [BCD_W-1:0] saved_value;
    logic             save_strobe;
    logic [SEG_W-1:0] segment_pattern;
    logic [BCD_W-1:0] display_value;
    logic             relay_on;
  } timer_out_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  bcd_countdown_timer_controller #(
    .DIGIT_COUNT(DIGITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Our own copy of the timer: configuration and state.
  logic [TICK_W-1:0] tick_ms_reg;
  logic [MPS_W-1:0]  ms_per_sec_reg;
  logic [BCD_W-1:0]  setting_q;
  logic [BCD_W-1:0]  countdown_q;
  int unsigned       ms_acc_q;
  logic              running_q;
  logic [3:0]        released_q;

  buttons_t    ticks_to_send[$];
  timer_out_t  expected_outputs[$];
  bit          steady_flow = 1'b0;
  bit          failed      = 1'b0;
  int unsigned cycle_count = 0;

  // BCD increment over the active digits. A nibble of nine or more rolls to
  // zero and carries, so non-decimal nibbles are cleaned up on the way.
  function automatic logic [BCD_W-1:0] bcd_step_up(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic [3:0]       d;
    bit               carry;
    r = v;
    carry = 1'b1;
    for (int k = 0; k < ACTIVE_DIGITS; k++) begin
      d = r[4*k +: 4];
      if (carry) begin
        if (d >= 4'd9) begin
          r[4*k +: 4] = 4'd0;
        end else begin
          r[4*k +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r & DIGIT_MASK;
  endfunction

  // BCD decrement: zero becomes nine with a borrow, any other nibble drops by one.
  function automatic logic [BCD_W-1:0] bcd_step_down(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic [3:0]       d;
    bit               borrow;
    r = v;
    borrow = 1'b1;
    for (int k = 0; k < ACTIVE_DIGITS; k++) begin
      d = r[4*k +: 4];
      if (borrow) begin
        if (d == 4'd0) begin
          r[4*k +: 4] = 4'd9;
        end else begin
          r[4*k +: 4] = d - 4'd1;
          borrow = 1'b0;
        end
      end
    end
    return r & DIGIT_MASK;
  endfunction

  // Nibbles above nine stay dark.
  function automatic logic [SEG_W-1:0] segments_of(input logic [BCD_W-1:0] v);
    logic [SEG_W-1:0] p;
    logic [3:0]       d;
    p = '0;
    for (int k = 0; k < ACTIVE_DIGITS; k++) begin
      d = v[4*k +: 4];
      if (d < 4'd10) begin
        p[7*k +: 7] = GLYPHS[d];
      end
    end
    return p;
  endfunction

  // One tick of the timer. The display shows the state from before the tick;
  // the sub-steps run in the order accumulate, inc, dec, save, start, decrement.
  function automatic timer_out_t advance_timer(input buttons_t b);
    timer_out_t  r;
    logic        was_running;
    int unsigned sum;
    r = '0;
    was_running = running_q;
    r.display_value = was_running ? countdown_q : setting_q;
    r.segment_pattern = segments_of(r.display_value);

    if (was_running) begin
      sum = ms_acc_q + 32'(tick_ms_reg);
      ms_acc_q = (sum > SAT_LIMIT) ? SAT_LIMIT : sum;
    end

    // Inc, dec and save only act on a fresh press while idle; running counts
    // as a release for them.
    if (!was_running && b.inc) begin
      if (released_q[BTN_INC]) begin
        setting_q = bcd_step_up(setting_q);
        released_q[BTN_INC] = 1'b0;
      end
    end else begin
      released_q[BTN_INC] = 1'b1;
    end

    if (!was_running && b.dec) begin
      if (released_q[BTN_DEC]) begin
        setting_q = bcd_step_down(setting_q);
        released_q[BTN_DEC] = 1'b0;
      end
    end else begin
      released_q[BTN_DEC] = 1'b1;
    end

    if (!was_running && b.save) begin
      if (released_q[BTN_SAVE]) begin
        r.save_strobe = 1'b1;
        r.saved_value = setting_q;
        released_q[BTN_SAVE] = 1'b0;
      end
    end else begin
      released_q[BTN_SAVE] = 1'b1;
    end

    // Start toggles: it stops a running count, or starts from a nonzero setting.
    if (b.start) begin
      if (released_q[BTN_START]) begin
        if (running_q) begin
          running_q = 1'b0;
        end else if (setting_q != '0) begin
          countdown_q = setting_q;
          ms_acc_q = 0;
          running_q = 1'b1;
        end
        released_q[BTN_START] = 1'b0;
      end
    end else begin
      released_q[BTN_START] = 1'b1;
    end

    if (running_q && ms_acc_q >= 32'(ms_per_sec_reg)) begin
      countdown_q = bcd_step_down(countdown_q);
      ms_acc_q = ms_acc_q - 32'(ms_per_sec_reg);
      if (countdown_q == '0) begin
        running_q = 1'b0;
      end
    end

    r.relay_on = running_q;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failed = 1'b1;
    end
  endtask

  // Driver: every accepted tick is run through the timer copy, and a new beat
  // is offered whenever the current one is gone, unless this cycle idles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outputs.push_back(advance_timer(buttons_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ticks_to_send.size() != 0 &&
            (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= ticks_to_send.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result beat is checked against the oldest expectation, and
  // the ready line stalls at random.
  always @(posedge clk_i) begin
    timer_out_t got;
    timer_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = timer_out_t'(m_axis_tdata);
        if (expected_outputs.size() == 0) begin
          $error("result beat 0x%0h arrived with no tick waiting for it", m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = expected_outputs.pop_front();
          compare_field("relay_on", 64'(want.relay_on), 64'(got.relay_on));
          compare_field("display_value", 64'(want.display_value), 64'(got.display_value));
          compare_field("segment_pattern", 64'(want.segment_pattern),
                        64'(got.segment_pattern));
          compare_field("save_strobe", 64'(want.save_strobe), 64'(got.save_strobe));
          compare_field("saved_value", 64'(want.saved_value), 64'(got.saved_value));
          compare_field("tdata pad", 64'(want.pad), 64'(got.pad));
        end
      end
      m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void push_tick(input logic [3:0] code);
    ticks_to_send.push_back(buttons_t'({4'b0000, code}));
  endfunction

  // Block until the sender has nothing left and every result is back. Every
  // tick yields a result, so the timer is idle once this returns.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (ticks_to_send.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
  endtask

  // Register write at one rising edge; our copy changes at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PRESET_TIME:   setting_q      = value & DIGIT_MASK;
      CFG_TICK_MS:       tick_ms_reg    = value[TICK_W-1:0];
      CFG_MS_PER_SECOND: ms_per_sec_reg = value[MPS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] preset,
                            input logic [CFG_DATA_W-1:0] tick,
                            input logic [CFG_DATA_W-1:0] threshold);
    write_reg(CFG_PRESET_TIME, preset);
    write_reg(CFG_TICK_MS, tick);
    write_reg(CFG_MS_PER_SECOND, threshold);
  endtask

  // Random use of the front panel: mostly single presses held for a tick or
  // three and then released, with quiet stretches so that counts can run out,
  // and a share of random button mixes as noise.
  task automatic queue_gestures(input int unsigned count);
    int unsigned pushed;
    int unsigned pick;
    int unsigned hold;
    int unsigned rest;
    logic [3:0]  code;
    pushed = 0;
    while (pushed < count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        code = PRESS_INC;
      end else if (pick < 55) begin
        code = PRESS_DEC;
      end else if (pick < 72) begin
        code = PRESS_START;
      end else if (pick < 87) begin
        code = PRESS_SAVE;
      end else begin
        code = 4'($urandom_range(15));
      end
      hold = $urandom_range(1, 3);
      rest = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      repeat (hold) begin
        push_tick(code);
        pushed++;
      end
      repeat (rest) begin
        push_tick(PRESS_NONE);
        pushed++;
      end
    end
  endtask

  initial begin
    tick_ms_reg    = TICK_RST;
    ms_per_sec_reg = MPS_RST;
    setting_q      = PRESET_RST & DIGIT_MASK;
    countdown_q    = '0;
    ms_acc_q       = 0;
    running_q      = 1'b0;
    released_q     = 4'b1111;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset settings: save, inc and dec with held buttons,
    // all buttons at once, start and stop, and presses ignored while running.
    push_tick(PRESS_NONE);
    push_tick(PRESS_SAVE);
    push_tick(PRESS_SAVE);
    push_tick(PRESS_INC);
    push_tick(PRESS_INC);
    push_tick(PRESS_DEC);
    push_tick(PRESS_INC | PRESS_DEC | PRESS_SAVE);
    push_tick(PRESS_START);
    push_tick(PRESS_START | PRESS_INC | PRESS_DEC | PRESS_SAVE);
    push_tick(PRESS_NONE);
    push_tick(PRESS_START);
    push_tick(PRESS_NONE);
    wait_drained();

    // Wrap from all nines up to zero and back down.
    write_reg(CFG_PRESET_TIME, 16'h9999);
    push_tick(PRESS_INC);
    push_tick(PRESS_NONE);
    push_tick(PRESS_DEC);
    wait_drained();

    // A zero setting must not start.
    write_reg(CFG_PRESET_TIME, 16'h0000);
    push_tick(PRESS_START);
    push_tick(PRESS_DEC);
    wait_drained();

    // Non-decimal nibbles, widest tick and a zero threshold, so that the
    // countdown drops on every running tick.
    set_timing(16'hFFFF, 16'd511, 16'd0);
    push_tick(PRESS_NONE);
    push_tick(PRESS_START);
    push_tick(PRESS_NONE);
    push_tick(PRESS_START);
    push_tick(PRESS_INC);
    push_tick(PRESS_DEC);
    wait_drained();

    // Random part, one setting per phase, the extremes among them.
    set_timing(16'h0009, 16'd500, 16'd1000);
    queue_gestures(160);
    wait_drained();
    // The sender sits still here until every result is back, then resumes.
    queue_gestures(150);
    wait_drained();

    set_timing(16'h0100, 16'd1, 16'd1);
    queue_gestures(310);
    wait_drained();

    // A long stretch with neither side idling.
    steady_flow = 1'b1;
    set_timing(16'h9999, 16'd511, 16'd0);
    queue_gestures(310);
    wait_drained();
    steady_flow = 1'b0;

    set_timing(16'h0000, 16'd20, 16'd4095);
    queue_gestures(300);
    wait_drained();

    set_timing(16'hFFFF, 16'd250, 16'd500);
    queue_gestures(300);
    wait_drained();

    set_timing(16'($urandom_range(16'hFFFF)), 16'($urandom_range(1, 511)),
               16'($urandom_range(4000)));
    queue_gestures(150);
    wait_drained();
    set_timing(16'h0001, 16'd1, 16'd4000);
    queue_gestures(150);
    wait_drained();

    // Let any stray beat show up before the verdict.
    repeat (8) @(posedge clk_i);
    if (!failed && expected_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== bcd_countdown_timer_controller.f =====
hw/rtl/bcdt_pkg.sv
hw/rtl/bcdt_bcd_step.sv
hw/rtl/bcdt_seg_enc.sv
hw/rtl/bcd_countdown_timer_controller.sv
tb/bcd_countdown_timer_controller_test.sv
